// ===== rtl/bole_pkg.sv =====
// Package: constants, types and codes for the bounded ordered list engine.
package bole_pkg;
	localparam int Depth = 16;
	localparam int IdxW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0, CMD_SEARCH = 3'd1, CMD_MODIFY = 3'd2,
		CMD_DELETE = 3'd3, CMD_REVERSE = 3'd4, CMD_SORT = 3'd5,
		CMD_RSVD6 = 3'd6, CMD_RSVD7 = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0, ST_FULL = 2'd1, ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE, FSM_WORK, FSM_OUT
	} fsm_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture request and run one command
		logic step;   // advance the walk by one step
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic done;   // walk finished, result registered
	} ctl_sts_t;
endpackage

// ===== rtl/bole_if.sv =====
// Interfaces: request and result channels.
interface bole_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic signed [31:0] value;
	logic signed [31:0] new_value;
	modport source (output valid, command, value, new_value, input ready);
	modport sink (input valid, command, value, new_value, output ready);
endinterface

interface bole_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [3:0] found_index;
	logic [4:0] entry_count;
	modport source (output valid, status, found_index, entry_count, input ready);
	modport sink (input valid, status, found_index, entry_count, output ready);
endinterface

// ===== rtl/bole_ctrl.sv =====
// Controller state machine: sequences one request at a time.
module bole_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output bole_pkg::ctl_cmd_t cmd,
	input  bole_pkg::ctl_sts_t sts
);
	bole_pkg::fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bole_pkg::FSM_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		case (state_q)
			bole_pkg::FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = bole_pkg::FSM_WORK;
				end
			end
			bole_pkg::FSM_WORK: begin
				if (sts.done) state_d = bole_pkg::FSM_OUT;
				else cmd.step = 1'b1;
			end
			bole_pkg::FSM_OUT: begin
				out_valid = 1'b1;
				in_ready = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d = bole_pkg::FSM_WORK;
					end else begin
						state_d = bole_pkg::FSM_IDLE;
					end
				end
			end
			default: state_d = bole_pkg::FSM_IDLE;
		endcase
	end
endmodule

// ===== rtl/bole_dp.sv =====
// Datapath: list storage, count, walk index and result registers.
module bole_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  bole_pkg::ctl_cmd_t cmd,
	output bole_pkg::ctl_sts_t sts,
	input  logic [2:0]         in_command,
	input  logic [31:0]        in_value,
	input  logic [31:0]        in_new_value,
	input  logic               cfg_we,
	input  logic [4:0]         cfg_wdata,
	output logic [1:0]         status,
	output logic [3:0]         found_index,
	output logic [4:0]         entry_count
);
	localparam int D = bole_pkg::Depth;
	localparam int IW = bole_pkg::IdxW;
	localparam int CW = bole_pkg::CntW;

	logic [31:0] ent_q [D];
	logic [CW-1:0] count_q;
	logic [4:0] cap_q;
	bole_pkg::cmd_t op_q;
	logic [31:0] val_q, nval_q;
	logic [CW-1:0] i_q;        // walk position
	logic [CW-1:0] j_q;        // sort inner position / reverse tail
	logic [31:0] key_q;        // sort element being placed
	logic sinner_q;            // sort inner phase
	logic done_q;
	logic [1:0] st_q;
	logic [IW-1:0] fi_q;

	logic [CW:0] cap_eff;
	assign cap_eff = ({1'b0, cap_q} > 6'(D)) ? (CW+1)'(D) : (CW+1)'(cap_q);

	logic [IW-1:0] ii, jm1, jj;
	assign ii = i_q[IW-1:0];
	assign jj = j_q[IW-1:0];
	assign jm1 = IW'(j_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= 5'd16;
		else if (cfg_we) cap_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q <= 1'b0;
			sinner_q <= 1'b0;
		end else if (cmd.load) begin
			op_q <= bole_pkg::cmd_t'(in_command);
			val_q <= in_value;
			nval_q <= in_new_value;
			done_q <= 1'b0;
			sinner_q <= 1'b0;
			st_q <= bole_pkg::ST_DONE;
			fi_q <= '0;
			i_q <= (in_command == bole_pkg::CMD_SORT) ? CW'(1) : '0;
			j_q <= count_q;
		end else if (cmd.step) begin
			case (op_q)
				bole_pkg::CMD_INSERT: begin
					// j_q counts shifts down from the tail
					if ((CW+1)'(count_q) >= cap_eff) begin
						st_q <= bole_pkg::ST_FULL;
						done_q <= 1'b1;
					end else if (j_q == '0) begin
						ent_q[0] <= val_q;
						count_q <= count_q + 1'b1;
						done_q <= 1'b1;
					end else begin
						ent_q[jj] <= ent_q[jm1];
						j_q <= j_q - 1'b1;
					end
				end
				bole_pkg::CMD_SEARCH, bole_pkg::CMD_MODIFY, bole_pkg::CMD_DELETE: begin
					if (!sinner_q) begin
						if (i_q >= count_q) begin
							st_q <= bole_pkg::ST_NOTFOUND;
							done_q <= 1'b1;
						end else if (ent_q[ii] == val_q) begin
							if (op_q == bole_pkg::CMD_SEARCH) begin
								fi_q <= ii;
								done_q <= 1'b1;
							end else if (op_q == bole_pkg::CMD_MODIFY) begin
								ent_q[ii] <= nval_q;
								done_q <= 1'b1;
							end else begin
								sinner_q <= 1'b1;   // close the gap
							end
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						if (i_q + 1'b1 < count_q) begin
							ent_q[ii] <= ent_q[IW'(i_q + 1'b1)];
							i_q <= i_q + 1'b1;
						end else begin
							count_q <= count_q - 1'b1;
							done_q <= 1'b1;
						end
					end
				end
				bole_pkg::CMD_REVERSE: begin
					if (i_q + 1'b1 < j_q) begin
						ent_q[ii] <= ent_q[jm1];
						ent_q[jm1] <= ent_q[ii];
						i_q <= i_q + 1'b1;
						j_q <= j_q - 1'b1;
					end else begin
						done_q <= 1'b1;
					end
				end
				bole_pkg::CMD_SORT: begin
					if (!sinner_q) begin
						if (i_q >= count_q) begin
							done_q <= 1'b1;
						end else begin
							key_q <= ent_q[ii];
							j_q <= i_q;
							sinner_q <= 1'b1;
						end
					end else begin
						if (j_q != '0 && $signed(key_q) < $signed(ent_q[jm1])) begin
							ent_q[jj] <= ent_q[jm1];
							j_q <= j_q - 1'b1;
						end else begin
							ent_q[jj] <= key_q;
							i_q <= i_q + 1'b1;
							sinner_q <= 1'b0;
						end
					end
				end
				default: done_q <= 1'b1;
			endcase
		end
	end

	assign sts.done = done_q;
	assign status = st_q;
	assign found_index = 4'(fi_q);
	assign entry_count = 5'(count_q);
endmodule

// ===== rtl/bounded_ordered_list_engine_core.sv =====
// Top level: bounded ordered list engine core.
// One request at a time: the next request is accepted only when the previous
// result is taken. Insert shifts entries one per step from the tail; search,
// modify and delete walk from the head; reverse swaps pairs from both ends;
// sort is a stable signed insertion sort over the stored entries.
// Reset (arst_n, async, active low) empties the list and sets capacity to 16;
// entry contents are not cleared.
module bounded_ordered_list_engine_core (
	input  logic          clk,
	input  logic          arst_n,
	bole_req_if.sink      req,
	bole_rsp_if.source    rsp,
	input  logic          cfg_we,
	input  logic [4:0]    cfg_wdata
);
	bole_pkg::ctl_cmd_t cmd;
	bole_pkg::ctl_sts_t sts;

	// controller owns the handshakes; result registers hold while stalled
	bole_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd(cmd), .sts(sts)
	);

	bole_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_command(req.command), .in_value(req.value),
		.in_new_value(req.new_value),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.status(rsp.status), .found_index(rsp.found_index),
		.entry_count(rsp.entry_count)
	);
endmodule

// ===== tb/bole_tb_if.sv =====
// Testbench package: watchdog limit.
package bole_tb_pkg;
	localparam int WatchLimit = 20000;
endpackage

// ===== tb/tb.sv =====
// Testbench for the bounded ordered list engine: directed and random requests, model-based check.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] found_index;
		logic [4:0] entry_count;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [4:0] cfg_wdata = '0;

	bole_req_if req ();
	bole_rsp_if rsp ();

	bounded_ordered_list_engine_core i_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Shadow of the list, the count and the capacity register.
	logic signed [31:0] list_q [bole_pkg::Depth];
	int unsigned list_len;
	int unsigned cap_reg;
	result_t pending_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int watch = 0;
	logic [31:0] used_vals[$];

	initial begin
		req.valid = 1'b0;
		req.command = '0;
		req.value = '0;
		req.new_value = '0;
		rsp.ready = 1'b0;
	end

	// Apply one command to the shadow list and return the expected result.
	function automatic result_t list_apply(bole_pkg::cmd_t c, logic signed [31:0] v,
			logic signed [31:0] nv);
		result_t r;
		int unsigned cap, pos, i, j;
		logic signed [31:0] t;
		r = '0;
		cap = (cap_reg < bole_pkg::Depth) ? cap_reg : bole_pkg::Depth;
		pos = list_len;
		for (i = 0; i < list_len; i++) begin
			if (list_q[i] == v && pos == list_len) pos = i;
		end
		case (c)
			bole_pkg::CMD_INSERT: begin
				if (list_len >= cap) r.status = bole_pkg::ST_FULL;
				else begin
					for (i = list_len; i > 0; i--) list_q[i] = list_q[i-1];
					list_q[0] = v;
					list_len++;
				end
			end
			bole_pkg::CMD_SEARCH: begin
				if (pos >= list_len) r.status = bole_pkg::ST_NOTFOUND;
				else r.found_index = pos[3:0];
			end
			bole_pkg::CMD_MODIFY: begin
				if (pos >= list_len) r.status = bole_pkg::ST_NOTFOUND;
				else list_q[pos] = nv;
			end
			bole_pkg::CMD_DELETE: begin
				if (pos >= list_len) r.status = bole_pkg::ST_NOTFOUND;
				else begin
					for (i = pos; i + 1 < list_len; i++) list_q[i] = list_q[i+1];
					list_len--;
				end
			end
			bole_pkg::CMD_REVERSE: begin
				i = 0;
				j = list_len;
				while (i + 1 < j) begin
					t = list_q[i];
					list_q[i] = list_q[j-1];
					list_q[j-1] = t;
					i++;
					j--;
				end
			end
			bole_pkg::CMD_SORT: begin
				// stable insertion sort, signed ascending
				for (i = 1; i < list_len; i++) begin
					t = list_q[i];
					j = i;
					while (j > 0 && t < list_q[j-1]) begin
						list_q[j] = list_q[j-1];
						j--;
					end
					list_q[j] = t;
				end
			end
			default: ;
		endcase
		r.entry_count = list_len[4:0];
		return r;
	endfunction

	// Send one request; prediction is made at acceptance. Valid stays high
	// after acceptance so the next request can follow with no gap.
	task automatic send_request(bole_pkg::cmd_t c, logic signed [31:0] v,
			logic signed [31:0] nv);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= c;
		req.value <= v;
		req.new_value <= nv;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pending_q.push_back(list_apply(c, v, nv));
		used_vals.push_back(v);
		if (used_vals.size() > 32) void'(used_vals.pop_front());
	endtask

	// Wait until every expected result has come, plus a tail for commands in flight.
	task automatic drain();
		req.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_capacity(int unsigned c);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= c[4:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = c;
	endtask

	// Receiver: random stall, check each accepted result.
	always @(posedge clk) begin
		result_t got, exp;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.status, rsp.found_index, rsp.entry_count};
				if (pending_q.size() == 0) begin
					$error("unexpected result %p", got);
					errors++;
				end else begin
					exp = pending_q.pop_front();
					if (got.status !== exp.status) begin
						$error("status exp %0d got %0d", exp.status, got.status);
						errors++;
					end
					if (got.found_index !== exp.found_index) begin
						$error("found_index exp %0d got %0d", exp.found_index,
							got.found_index);
						errors++;
					end
					if (got.entry_count !== exp.entry_count) begin
						$error("entry_count exp %0d got %0d", exp.entry_count,
							got.entry_count);
						errors++;
					end
				end
			end
			rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
		end
	end

	// Watchdog: cycles with no request and no result accepted.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n) watch <= 0;
		else watch <= watch + 1;
		if (watch >= bole_tb_pkg::WatchLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick_value();
		if (used_vals.size() > 0 && $urandom_range(2, 0) != 0)
			return used_vals[$urandom_range(used_vals.size() - 1, 0)];
		if ($urandom_range(3, 0) == 0) return $urandom_range(7, 0) - 4;
		return $urandom();
	endfunction

	task automatic test_directed();
		send_request(bole_pkg::CMD_SEARCH, 0, 0);       // empty list cases
		send_request(bole_pkg::CMD_MODIFY, 0, 1);
		send_request(bole_pkg::CMD_DELETE, 0, 0);
		send_request(bole_pkg::CMD_REVERSE, 0, 0);
		send_request(bole_pkg::CMD_SORT, 0, 0);
		send_request(bole_pkg::CMD_INSERT, 32'h7fffffff, 0);
		send_request(bole_pkg::CMD_INSERT, 32'h80000000, 0);
		send_request(bole_pkg::CMD_INSERT, 5, 0);
		send_request(bole_pkg::CMD_INSERT, 5, 0);       // duplicate for stability
		send_request(bole_pkg::CMD_INSERT, -1, 0);
		send_request(bole_pkg::CMD_SEARCH, 5, 0);
		send_request(bole_pkg::CMD_SEARCH, 32'h7fffffff, 0);
		send_request(bole_pkg::CMD_MODIFY, 5, 32'hffffffff);
		send_request(bole_pkg::CMD_SORT, 0, 0);
		send_request(bole_pkg::CMD_REVERSE, 0, 0);
		send_request(bole_pkg::CMD_DELETE, -1, 0);
		send_request(bole_pkg::CMD_DELETE, 1234, 0);
		send_request(bole_pkg::CMD_RSVD6, 32'hffffffff, 32'hffffffff);
		send_request(bole_pkg::CMD_RSVD7, 0, 0);
		write_capacity(2);                     // below count: insert reports full
		send_request(bole_pkg::CMD_INSERT, 9, 0);
		write_capacity(0);
		send_request(bole_pkg::CMD_INSERT, 9, 0);
		write_capacity(31);                    // above depth: depth rules
	endtask

	task automatic test_fill_to_depth();
		repeat (20) send_request(bole_pkg::CMD_INSERT, $urandom(), $urandom());
		send_request(bole_pkg::CMD_SORT, 0, 0);
		send_request(bole_pkg::CMD_REVERSE, 0, 0);
	endtask

	// Random phase: inserts weighted so the list stays mostly populated.
	task automatic test_random(int n, int idle, int stall);
		int k;
		bole_pkg::cmd_t c;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(15, 0))
				0, 1, 2, 3, 4: c = bole_pkg::CMD_INSERT;
				5, 6: c = bole_pkg::CMD_SEARCH;
				7, 8: c = bole_pkg::CMD_MODIFY;
				9, 10, 11: c = bole_pkg::CMD_DELETE;
				12: c = bole_pkg::CMD_REVERSE;
				13, 14: c = bole_pkg::CMD_SORT;
				default: c = bole_pkg::cmd_t'($urandom_range(7, 0));
			endcase
			send_request(c, pick_value(), $urandom());
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		list_len = 0;
		cap_reg = 16;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_to_depth();
		test_random(250, 0, 0);
		write_capacity(5);
		test_random(250, 68, 0);
		drain();                               // sender holds until all results in
		write_capacity(16);
		test_random(250, 0, 68);
		write_capacity($urandom_range(16, 1));
		test_random(250, 6, 6);
		drain();
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule

// ===== bounded_ordered_list_engine_core.f =====
rtl/bole_pkg.sv
rtl/bole_if.sv
rtl/bole_ctrl.sv
rtl/bole_dp.sv
rtl/bounded_ordered_list_engine_core.sv
tb/bole_tb_if.sv
tb/tb.sv
